@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the UART ring buffer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ sv/udrb_pkg.sv @@
// ----------------------------------------------------------------------------
// UART dual ring buffer package
// Command and register codes, default depths and a count saturation helper.
// ----------------------------------------------------------------------------
package udrb_pkg;

  localparam int DEF_RX_DEPTH = 256;
  localparam int DEF_TX_DEPTH = 256;

  // Wide enough for any count up to the largest supported depth.
  localparam int CNT_W = 13;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    CMD_RX_BYTE  = 3'd0,
    CMD_TX_READY = 3'd1,
    CMD_GET_CHAR = 3'd2,
    CMD_PUT_CHAR = 3'd3,
    CMD_DRAIN_TX = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_MODE = 2'd0,
    REG_RX_NOTIFY = 2'd1
  } reg_idx_t;

  // Clamp a count to the 8-bit reporting range.
  function automatic logic [7:0] sat8(input logic [CNT_W-1:0] v);
    logic [7:0] res;
    if (v > CNT_W'(255)) res = 8'hFF;
    else res = v[7:0];
    return res;
  endfunction

endpackage

@@ sv/uart_dual_ring_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// UART dual ring buffer unit
// Receive and transmit byte rings for a UART, one result per request.
// ----------------------------------------------------------------------------
// A request passes through the pending stage and then the output register.
// At the accepting edge the ring pointers update, the ring memory is read or
// written and the request's flags enter the pending stage. Once the output
// register is free, the registered memory read data joins the pending
// flags and the updated counts in the output register. A new request is
// taken only while the pending stage is empty; holding requests off keeps
// the pointers and read data of the pending request intact until its result
// is formed. The output register acts as a skid stage: a new request can be
// taken while an earlier result is still waiting on the result channel.
// Both rings live in synchronous single-port style memories with no reset;
// a received byte is written without a full check and overwrites old data.
`include "assert_macros.svh"

module uart_dual_ring_buffer_unit
  import udrb_pkg::*;
#(
  parameter int RX_DEPTH = DEF_RX_DEPTH,
  parameter int TX_DEPTH = DEF_TX_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic                 cfg_wdata,
  // Request channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_cmd,
  input  logic [7:0]           in_data_in,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_status,
  output logic                 out_read_valid,
  output logic [7:0]           out_read_byte,
  output logic                 out_send_valid,
  output logic [7:0]           out_send_byte,
  output logic                 out_notify_valid,
  output logic [7:0]           out_notify_byte,
  output logic [7:0]           out_rx_count,
  output logic [7:0]           out_tx_free,
  output logic                 out_tx_irq_on
);

  localparam int RXW = $clog2(RX_DEPTH);
  localparam int TXW = $clog2(TX_DEPTH);

  // Ring storage. Entries are undefined until written.
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_rd_q;
  logic [7:0] tx_rd_q;

  // Ring pointers and control.
  logic [RXW-1:0] rx_wr_r, rx_wr_nxt, rx_rd_r, rx_rd_nxt;
  logic [TXW-1:0] tx_wr_r, tx_wr_nxt, tx_rd_r, tx_rd_nxt;
  logic           irq_r, irq_nxt;
  logic           sync_mode_r, rx_notify_r;

  // Pending stage: result of the last accepted request, held until the output register takes it.
  logic       pend_r;
  logic       p_status_r, p_rv_r, p_sv_r, p_send_mem_r, p_nv_r;
  logic [7:0] p_data_r;
  logic       p_status_nxt, p_rv_nxt, p_sv_nxt, p_send_mem_nxt, p_nv_nxt;

  // Memory controls for the request being accepted.
  logic rx_we, rx_re, tx_we, tx_re;

  logic accept;
  logic out_valid_r;
  logic out_free;

  logic [RXW:0] rx_used;
  logic [TXW:0] tx_used;
  logic [TXW:0] tx_free;
  logic [TXW:0] tx_used_cur;

  assign accept   = in_valid && !in_stall;
  assign in_stall = pend_r;
  assign out_free = !out_valid_r || !out_stall;

  // Occupancy from the current pointers; these settle during the pending
  // cycle and are captured with the result.
  always_comb begin
    if (rx_wr_r >= rx_rd_r) begin
      rx_used = {1'b0, rx_wr_r} - {1'b0, rx_rd_r};
    end else begin
      rx_used = {1'b0, rx_wr_r} + (RXW+1)'(RX_DEPTH) - {1'b0, rx_rd_r};
    end
    if (tx_wr_r >= tx_rd_r) begin
      tx_used = {1'b0, tx_wr_r} - {1'b0, tx_rd_r};
    end else begin
      tx_used = {1'b0, tx_wr_r} + (TXW+1)'(TX_DEPTH) - {1'b0, tx_rd_r};
    end
    tx_free     = (TXW+1)'(TX_DEPTH - 1) - tx_used;
    tx_used_cur = tx_used;
  end

  // Request decode: pointer updates, memory accesses and result flags.
  always_comb begin
    rx_wr_nxt      = rx_wr_r;
    rx_rd_nxt      = rx_rd_r;
    tx_wr_nxt      = tx_wr_r;
    tx_rd_nxt      = tx_rd_r;
    irq_nxt        = irq_r;
    rx_we          = 1'b0;
    rx_re          = 1'b0;
    tx_we          = 1'b0;
    tx_re          = 1'b0;
    p_status_nxt   = 1'b0;
    p_rv_nxt       = 1'b0;
    p_sv_nxt       = 1'b0;
    p_send_mem_nxt = 1'b0;
    p_nv_nxt       = 1'b0;
    if (accept) begin
      unique case (in_cmd)
        CMD_RX_BYTE: begin
          rx_we     = 1'b1;
          rx_wr_nxt = (rx_wr_r == RXW'(RX_DEPTH - 1)) ? '0 : rx_wr_r + 1'b1;
          p_nv_nxt  = rx_notify_r;
        end
        CMD_TX_READY: begin
          if (sync_mode_r) begin
            irq_nxt = 1'b0;
          end else begin
            if (tx_wr_r != tx_rd_r) begin
              tx_re          = 1'b1;
              p_sv_nxt       = 1'b1;
              p_send_mem_nxt = 1'b1;
              tx_rd_nxt = (tx_rd_r == TXW'(TX_DEPTH - 1)) ? '0 : tx_rd_r + 1'b1;
            end
            if (tx_wr_r == tx_rd_nxt) irq_nxt = 1'b0;
          end
        end
        CMD_GET_CHAR: begin
          if (rx_rd_r != rx_wr_r) begin
            rx_re     = 1'b1;
            p_rv_nxt  = 1'b1;
            rx_rd_nxt = (rx_rd_r == RXW'(RX_DEPTH - 1)) ? '0 : rx_rd_r + 1'b1;
          end else begin
            p_status_nxt = 1'b1;
          end
        end
        CMD_PUT_CHAR: begin
          if (sync_mode_r) begin
            p_sv_nxt = 1'b1;
          end else begin
            // One slot stays unused so that full and empty differ.
            if (tx_used_cur != (TXW+1)'(TX_DEPTH - 1)) begin
              tx_we     = 1'b1;
              tx_wr_nxt = (tx_wr_r == TXW'(TX_DEPTH - 1)) ? '0 : tx_wr_r + 1'b1;
            end else begin
              p_status_nxt = 1'b1;
            end
            irq_nxt = 1'b1;
          end
        end
        CMD_DRAIN_TX: begin
          tx_wr_nxt = '0;
          tx_rd_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Receive ring memory.
  always_ff @(posedge clk) begin
    if (rx_we) rx_mem[rx_wr_r] <= in_data_in;
    if (rx_re) rx_rd_q <= rx_mem[rx_rd_r];
  end

  // Transmit ring memory.
  always_ff @(posedge clk) begin
    if (tx_we) tx_mem[tx_wr_r] <= in_data_in;
    if (tx_re) tx_rd_q <= tx_mem[tx_rd_r];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wr_r     <= '0;
      rx_rd_r     <= '0;
      tx_wr_r     <= '0;
      tx_rd_r     <= '0;
      irq_r       <= 1'b0;
      sync_mode_r <= 1'b0;
      rx_notify_r <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rx_wr_r <= rx_wr_nxt;
      rx_rd_r <= rx_rd_nxt;
      tx_wr_r <= tx_wr_nxt;
      tx_rd_r <= tx_rd_nxt;
      irq_r   <= irq_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_SYNC_MODE: sync_mode_r <= cfg_wdata;
          REG_RX_NOTIFY: rx_notify_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (accept) begin
        pend_r <= 1'b1;
      end else if (pend_r && out_free) begin
        pend_r <= 1'b0;
      end
      if (pend_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pending stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_status_r   <= p_status_nxt;
      p_rv_r       <= p_rv_nxt;
      p_sv_r       <= p_sv_nxt;
      p_send_mem_r <= p_send_mem_nxt;
      p_nv_r       <= p_nv_nxt;
      p_data_r     <= in_data_in;
    end
  end

  // Output register: memory read data joins the result here.
  always_ff @(posedge clk) begin
    if (pend_r && out_free) begin
      out_status       <= p_status_r;
      out_read_valid   <= p_rv_r;
      out_read_byte    <= p_rv_r ? rx_rd_q : 8'h00;
      out_send_valid   <= p_sv_r;
      out_send_byte    <= !p_sv_r ? 8'h00 : (p_send_mem_r ? tx_rd_q : p_data_r);
      out_notify_valid <= p_nv_r;
      out_notify_byte  <= p_nv_r ? p_data_r : 8'h00;
      out_rx_count     <= sat8(CNT_W'(rx_used));
      out_tx_free      <= sat8(CNT_W'(tx_free));
      out_tx_irq_on    <= irq_r;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_CLK(a_accept_sets_pend, clk, rst_n, accept |=> pend_r)
  `ASSERT_CLK(a_pend_holds, clk, rst_n, (pend_r && !out_free) |=> pend_r)
  `ASSERT_CLK(a_read_not_status, clk, rst_n, (out_valid && out_read_valid) |-> !out_status)
  `ASSERT_CLK(a_one_action, clk, rst_n,
              out_valid |-> !(out_read_valid && (out_send_valid || out_notify_valid)))

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART dual ring buffer testbench
// Drives receive, transmit-ready, get, put, drain and unused requests into
// the ring buffer unit under random idling on both channels. It predicts each
// result from its own copy of both rings and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top
  import udrb_pkg::*;
();

  // Command codes 5 to 7 are not decoded by the block.
  localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [2:0] CMD_RSVD_MID   = 3'd6;
  localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

  // Percentage of cycles in which either side idles.
  localparam int IDLE_PCT = 33;
  // Settling time for the pending stage and the output register.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 20;
  // Keep the log short if the block is badly broken.
  localparam int MAX_REPORTS = 50;

  localparam logic [7:0] TX_USABLE = 8'(DEF_TX_DEPTH - 1);

  // One result of the block, in port order.
  typedef struct packed {
    logic       status;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       notify_valid;
    logic [7:0] notify_byte;
    logic [7:0] rx_count;
    logic [7:0] tx_free;
    logic       tx_irq_on;
  } ring_reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  reg_idx_t   cfg_addr = REG_SYNC_MODE;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_cmd = CMD_RX_BYTE;
  logic [7:0] in_data_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_status;
  logic       out_read_valid;
  logic [7:0] out_read_byte;
  logic       out_send_valid;
  logic [7:0] out_send_byte;
  logic       out_notify_valid;
  logic [7:0] out_notify_byte;
  logic [7:0] out_rx_count;
  logic [7:0] out_tx_free;
  logic       out_tx_irq_on;

  // Predicted state of the block. The 8-bit pointers span exactly the 256-entry
  // depth, so they wrap on their own.
  logic [7:0] rx_ring [DEF_RX_DEPTH];
  logic [7:0] tx_ring [DEF_TX_DEPTH];
  logic [7:0] rx_wr_ptr = 8'd0;
  logic [7:0] rx_rd_ptr = 8'd0;
  logic [7:0] tx_wr_ptr = 8'd0;
  logic [7:0] tx_rd_ptr = 8'd0;
  logic       tx_irq_en = 1'b0;
  logic       sync_on = 1'b0;
  logic       notify_on = 1'b0;

  // Results predicted for accepted requests, oldest first.
  ring_reply_t awaited_replies [$];
  int mismatch_count = 0;
  // Set during one long stretch in which neither side idles.
  bit no_idle = 1'b0;

  uart_dual_ring_buffer_unit #(
    .RX_DEPTH(DEF_RX_DEPTH),
    .TX_DEPTH(DEF_TX_DEPTH)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_data_in       (in_data_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_read_valid   (out_read_valid),
    .out_read_byte    (out_read_byte),
    .out_send_valid   (out_send_valid),
    .out_send_byte    (out_send_byte),
    .out_notify_valid (out_notify_valid),
    .out_notify_byte  (out_notify_byte),
    .out_rx_count     (out_rx_count),
    .out_tx_free      (out_tx_free),
    .out_tx_irq_on    (out_tx_irq_on)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one request to the predicted rings and return the result the
  // block must report for it.
  function automatic ring_reply_t apply_ring_request(input logic [2:0] cmd,
                                                     input logic [7:0] data);
    ring_reply_t r;
    logic [7:0] tx_used;
    r = '0;
    case (cmd)
      CMD_RX_BYTE: begin
        // No full check: a full ring wraps onto the read pointer and then
        // reads as empty, losing everything that was waiting.
        rx_ring[rx_wr_ptr] = data;
        rx_wr_ptr = rx_wr_ptr + 8'd1;
        if (notify_on) begin
          r.notify_valid = 1'b1;
          r.notify_byte = data;
        end
      end
      CMD_TX_READY: begin
        if (sync_on) begin
          tx_irq_en = 1'b0;
        end else begin
          if (tx_wr_ptr != tx_rd_ptr) begin
            r.send_valid = 1'b1;
            r.send_byte = tx_ring[tx_rd_ptr];
            tx_rd_ptr = tx_rd_ptr + 8'd1;
          end
          if (tx_wr_ptr == tx_rd_ptr) tx_irq_en = 1'b0;
        end
      end
      CMD_GET_CHAR: begin
        if (rx_rd_ptr != rx_wr_ptr) begin
          r.read_valid = 1'b1;
          r.read_byte = rx_ring[rx_rd_ptr];
          rx_rd_ptr = rx_rd_ptr + 8'd1;
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_PUT_CHAR: begin
        if (sync_on) begin
          r.send_valid = 1'b1;
          r.send_byte = data;
        end else begin
          // One slot always stays unused, so the ring is full at 255 bytes.
          tx_used = tx_wr_ptr - tx_rd_ptr;
          if (tx_used != TX_USABLE) begin
            tx_ring[tx_wr_ptr] = data;
            tx_wr_ptr = tx_wr_ptr + 8'd1;
          end else begin
            r.status = 1'b1;
          end
          // The interrupt is enabled even when the byte did not fit.
          tx_irq_en = 1'b1;
        end
      end
      CMD_DRAIN_TX: begin
        tx_wr_ptr = 8'd0;
        tx_rd_ptr = 8'd0;
      end
      default: ;
    endcase
    tx_used = tx_wr_ptr - tx_rd_ptr;
    r.rx_count = rx_wr_ptr - rx_rd_ptr;
    r.tx_free = TX_USABLE - tx_used;
    r.tx_irq_on = tx_irq_en;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // The result side stalls at random, except during the no-idle stretch.
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99, 0) < IDLE_PCT);
  end

  // Every result taken on the channel is compared with the oldest prediction.
  always @(posedge clk) begin
    ring_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t ns: result expected none, got status %0d rx_count %0d tx_free %0d",
                   $time, out_status, out_rx_count, out_tx_free);
      end else begin
        want = awaited_replies.pop_front();
        check_field("status", want.status, out_status);
        check_field("read_valid", want.read_valid, out_read_valid);
        check_field("read_byte", want.read_byte, out_read_byte);
        check_field("send_valid", want.send_valid, out_send_valid);
        check_field("send_byte", want.send_byte, out_send_byte);
        check_field("notify_valid", want.notify_valid, out_notify_valid);
        check_field("notify_byte", want.notify_byte, out_notify_byte);
        check_field("rx_count", want.rx_count, out_rx_count);
        check_field("tx_free", want.tx_free, out_tx_free);
        check_field("tx_irq_on", want.tx_irq_on, out_tx_irq_on);
      end
    end
  end

  // Send one request. Valid is left high after acceptance so that a request
  // that follows at once goes out without a bubble; whoever stops sending
  // lowers it.
  task automatic send_request(input logic [2:0] cmd, input logic [7:0] data);
    while (!no_idle && $urandom_range(99, 0) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_data_in <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_replies.push_back(apply_ring_request(cmd, data));
  endtask

  // Stop sending and wait until every predicted result has been checked,
  // then let the pipeline settle.
  task automatic wait_replies_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers are only written while the block is idle.
  task automatic write_register(input reg_idx_t idx, input logic value);
    wait_replies_drained();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SYNC_MODE: sync_on = value;
      REG_RX_NOTIFY: notify_on = value;
      default: ;
    endcase
  endtask

  task automatic set_mode(input logic sync_val, input logic notify_val);
    write_register(REG_SYNC_MODE, sync_val);
    write_register(REG_RX_NOTIFY, notify_val);
  endtask

  // Extremes of both fields and every command, starting from reset state.
  task automatic test_directed_ops();
    send_request(CMD_GET_CHAR, 8'h00);    // empty receive ring reports status
    send_request(CMD_TX_READY, 8'h00);    // nothing queued, nothing sent
    send_request(CMD_PUT_CHAR, 8'h00);
    send_request(CMD_PUT_CHAR, 8'hFF);
    send_request(CMD_TX_READY, 8'hFF);
    send_request(CMD_TX_READY, 8'h00);    // ring empties, interrupt drops
    send_request(CMD_PUT_CHAR, 8'h5A);
    send_request(CMD_DRAIN_TX, 8'hA5);    // pointers cleared, interrupt kept
    send_request(CMD_TX_READY, 8'h00);    // empty after drain, interrupt drops
    send_request(CMD_RX_BYTE, 8'h00);
    send_request(CMD_RX_BYTE, 8'hFF);
    send_request(CMD_RX_BYTE, 8'hA5);
    send_request(CMD_GET_CHAR, 8'hFF);
    send_request(CMD_GET_CHAR, 8'h00);
    send_request(CMD_GET_CHAR, 8'h00);
    send_request(CMD_GET_CHAR, 8'h00);
    send_request(CMD_RSVD_FIRST, 8'hFF);  // unused commands change nothing
    send_request(CMD_RSVD_MID, 8'h00);
    send_request(CMD_RSVD_LAST, 8'h5A);
    send_request(CMD_PUT_CHAR, 8'h3C);    // leaves a byte and the interrupt on
  endtask

  // Sync mode bypasses the transmit ring; notify reports received bytes.
  task automatic test_sync_mode();
    set_mode(1'b1, 1'b1);
    send_request(CMD_TX_READY, 8'h00);    // nothing sent, interrupt cleared
    send_request(CMD_PUT_CHAR, 8'hFF);    // sent at once
    send_request(CMD_PUT_CHAR, 8'h00);
    send_request(CMD_RX_BYTE, 8'hC3);
    send_request(CMD_GET_CHAR, 8'h00);
  endtask

  // Fill the receive ring past its depth: the write pointer lands on the
  // read pointer and the waiting bytes are lost.
  task automatic test_rx_overrun();
    set_mode(1'b0, 1'b1);
    while (rx_wr_ptr != rx_rd_ptr) send_request(CMD_GET_CHAR, 8'($urandom));
    repeat (DEF_RX_DEPTH) send_request(CMD_RX_BYTE, 8'($urandom));
    send_request(CMD_GET_CHAR, 8'($urandom));
    send_request(CMD_RX_BYTE, 8'($urandom));
    send_request(CMD_GET_CHAR, 8'($urandom));
  endtask

  // Fill the transmit ring until a put is refused, then send a few bytes.
  // Neither side idles here, which gives one long back-to-back stretch.
  task automatic test_tx_full();
    set_mode(1'b0, 1'b0);
    no_idle = 1'b1;
    send_request(CMD_DRAIN_TX, 8'($urandom));
    repeat (int'(TX_USABLE)) send_request(CMD_PUT_CHAR, 8'($urandom));
    send_request(CMD_PUT_CHAR, 8'($urandom));   // full, refused
    repeat (4) send_request(CMD_TX_READY, 8'($urandom));
    send_request(CMD_PUT_CHAR, 8'($urandom));
    send_request(CMD_DRAIN_TX, 8'($urandom));
    no_idle = 1'b0;
  endtask

  // Weighted random requests with random data under one mode setting. Half
  // way through the sender holds off until every result is back.
  task automatic test_random_mix(input logic sync_val, input logic notify_val,
                                 input int count);
    int pick;
    logic [2:0] cmd;
    set_mode(sync_val, notify_val);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_replies_drained();
      pick = $urandom_range(99, 0);
      if (pick < 25) cmd = CMD_RX_BYTE;
      else if (pick < 45) cmd = CMD_TX_READY;
      else if (pick < 70) cmd = CMD_GET_CHAR;
      else if (pick < 95) cmd = CMD_PUT_CHAR;
      else if (pick < 98) cmd = CMD_DRAIN_TX;
      else cmd = 3'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST));
      send_request(cmd, 8'($urandom));
    end
  endtask

  initial begin
    // Synchronous reset held at the start.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_sync_mode();
    test_rx_overrun();
    test_tx_full();
    test_random_mix(1'b0, 1'b1, 40);
    test_random_mix(1'b1, 1'b0, 40);
    test_random_mix(1'b1, 1'b1, 40);
    test_random_mix(1'b0, 1'b0, 60);

    wait_replies_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // A time limit far beyond a correct run; reaching it counts as a failure.
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
